// ----- rtl/core/rmpt_pkg.sv -----
// Package for the range max point update table.
// Holds widths, node type, opcodes and the pick function; no dependencies.
`timescale 1ns / 1ps
package rmpt_pkg;
  localparam int ENTRIES = 1024;
  localparam int IW = $clog2(ENTRIES);
  localparam int AW = IW + 1;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_QUERY = 2'd1;
  localparam logic [1:0] FUNC_TAKE  = 2'd2;
  localparam logic [1:0] FUNC_NOP   = 2'd3;

  typedef struct packed {
    logic signed [31:0] val;
    logic [IW-1:0]      pos;
  } node_t;

  function automatic node_t pick(node_t a, node_t b);
    if (a.val > b.val) return a;
    if (b.val > a.val) return b;
    return (a.pos <= b.pos) ? a : b;
  endfunction
endpackage

// ----- rtl/core/range_max_point_update_table_top.sv -----
// Top level of the range max point update table.
// Depends on rmpt_pkg and rmpt_ctrl.
//  channel | dir | fields
//  s_axis  | in  | tdata: func[1:0] index[11:2] high_index[21:12] value[53:22]
//  m_axis  | out | tdata: max_value[31:0] max_index[41:32] range_ok[42]
// A write does one memory read per tree level.
// A query walks the tree levels of its range, plus the update path for func 2.
// Reset is synchronous; a clearing pass over all 2*ENTRIES nodes follows, input held off.
// A pending result holds in the output register until taken; no new item is taken.
`timescale 1ns / 1ps
module range_max_point_update_table_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // func, index, high_index, value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // max_value, max_index, range_ok
);
  rmpt_pkg::node_t res_node;
  logic res_ok;

  rmpt_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .func(s_axis_tdata[1:0]), .lo(s_axis_tdata[11:2]), .hi(s_axis_tdata[21:12]),
    .value(s_axis_tdata[53:22]),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .res_node, .res_ok
  );

  assign m_axis_tdata = {5'b0, res_ok, res_node.pos, res_node.val};
endmodule

// ----- rtl/core/rmpt_mem.sv -----
// Tree node memory: one synchronous write port, one registered read port.
// After reset a clearing pass writes the reset node of every address; busy while it runs.
// Depends on rmpt_pkg.
`timescale 1ns / 1ps
module rmpt_mem (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  we,
  input  logic [rmpt_pkg::AW-1:0] waddr,
  input  rmpt_pkg::node_t       wdata,
  input  logic [rmpt_pkg::AW-1:0] raddr,
  output rmpt_pkg::node_t       rdata,
  output logic                  busy
);
  localparam int DEPTH = 2 * rmpt_pkg::ENTRIES;
  rmpt_pkg::node_t mem [DEPTH];
  rmpt_pkg::node_t rd;
  logic clearing;
  logic [rmpt_pkg::AW-1:0] clr_addr;
  rmpt_pkg::node_t clr_node;

  // Reset node: value zero, position of the leftmost leaf below the node.
  function automatic logic [rmpt_pkg::IW-1:0] left_leaf(logic [rmpt_pkg::AW-1:0] a);
    logic [rmpt_pkg::AW-1:0] x;
    x = a;
    for (int i = 0; i < rmpt_pkg::AW; i++) begin
      if (!x[rmpt_pkg::AW-1] && x != '0) x = x << 1;
    end
    return x[rmpt_pkg::IW-1:0];
  endfunction

  always_comb begin
    clr_node.val = '0;
    clr_node.pos = left_leaf(clr_addr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == rmpt_pkg::AW'(DEPTH - 1)) clearing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) mem[clr_addr] <= clr_node;
    else if (we) mem[waddr] <= wdata;
    rd <= mem[raddr];
  end

  assign rdata = rd;
  assign busy = clearing;
endmodule

// ----- rtl/core/rmpt_ctrl.sv -----
// Sequencer: walks query paths and rebuilds the update path through rmpt_mem.
// Depends on rmpt_pkg and rmpt_mem.
`timescale 1ns / 1ps
module rmpt_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              func,
  input  logic [rmpt_pkg::IW-1:0] lo,
  input  logic [rmpt_pkg::IW-1:0] hi,
  input  logic signed [31:0]      value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output rmpt_pkg::node_t         res_node,
  output logic                    res_ok
);
  localparam int AW = rmpt_pkg::AW;
  localparam int IW = rmpt_pkg::IW;
  localparam logic [AW:0] BASE = (AW+1)'(rmpt_pkg::ENTRIES);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_QL = 7'b0000010, S_QLW = 7'b0000100,
    S_QR = 7'b0001000, S_QRW = 7'b0010000, S_UP = 7'b0100000,
    S_UPW = 7'b1000000
  } state_t;

  state_t state;
  logic [AW:0] l, r;
  logic [AW-1:0] p;
  rmpt_pkg::node_t res, cur;
  logic have, take;
  logic we;
  logic busy;
  logic [AW-1:0] waddr, raddr;
  rmpt_pkg::node_t wdata, rdata;
  logic [AW-1:0] sib;

  rmpt_mem u_mem (.clk, .rst, .we, .waddr, .wdata, .raddr, .rdata, .busy);

  assign in_ready = (state == S_IDLE) && !out_valid && !busy;
  assign sib = p ^ AW'(1);

  always_comb begin
    raddr = '0;
    case (state)
      S_QL: raddr = l[AW-1:0];
      S_QR: raddr = AW'(r - 1'b1);
      S_UP: raddr = sib;
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      we <= 1'b0;
    end else begin
      we <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            if (func == rmpt_pkg::FUNC_WRITE) begin
              p <= AW'(BASE + (AW+1)'(lo));
              cur.val <= value;
              cur.pos <= lo;
              we <= 1'b1;
              waddr <= AW'(BASE + (AW+1)'(lo));
              wdata.val <= value;
              wdata.pos <= lo;
              state <= S_UP;
            end else if (func == rmpt_pkg::FUNC_QUERY || func == rmpt_pkg::FUNC_TAKE) begin
              take <= (func == rmpt_pkg::FUNC_TAKE);
              res_ok <= (lo <= hi);
              res <= '0;
              have <= 1'b0;
              l <= BASE + (AW+1)'(lo);
              r <= BASE + (AW+1)'(hi) + 1'b1;
              if (lo > hi) begin
                res_node <= '0;
                out_valid <= 1'b1;
              end else state <= S_QL;
            end
          end
        end
        S_QL: begin
          if (l >= r) begin
            res_node <= res;
            out_valid <= 1'b1;
            if (take && have) begin
              p <= AW'(BASE + (AW+1)'(res.pos));
              cur.val <= -32'sd1;
              cur.pos <= res.pos;
              we <= 1'b1;
              waddr <= AW'(BASE + (AW+1)'(res.pos));
              wdata.val <= -32'sd1;
              wdata.pos <= res.pos;
              state <= S_UP;
            end else state <= S_IDLE;
          end else if (l[0]) state <= S_QLW;
          else state <= S_QR;
        end
        S_QLW: begin
          res <= have ? rmpt_pkg::pick(res, rdata) : rdata;
          have <= 1'b1;
          l <= l + 1'b1;
          state <= S_QR;
        end
        S_QR: begin
          if (r[0]) state <= S_QRW;
          else begin
            l <= l >> 1;
            r <= r >> 1;
            state <= S_QL;
          end
        end
        S_QRW: begin
          res <= have ? rmpt_pkg::pick(res, rdata) : rdata;
          have <= 1'b1;
          l <= l >> 1;
          r <= (r - 1'b1) >> 1;
          state <= S_QL;
        end
        S_UP: begin
          if (p <= AW'(1)) state <= S_IDLE;
          else state <= S_UPW;
        end
        S_UPW: begin
          cur <= p[0] ? rmpt_pkg::pick(rdata, cur) : rmpt_pkg::pick(cur, rdata);
          wdata <= p[0] ? rmpt_pkg::pick(rdata, cur) : rmpt_pkg::pick(cur, rdata);
          waddr <= p >> 1;
          we <= 1'b1;
          p <= p >> 1;
          state <= S_UP;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_bad_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !res_ok |-> res_node == '0) else $error("bad range result");
  a_write_up: assert property (@(posedge clk) disable iff (rst)
    state == S_UPW |=> we) else $error("missed write back");
endmodule
